@@ rtl/sdbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sdbc_pkg
// Shared types and constants of the sample DMA buffer cache.
// ----------------------------------------------------------------------------
package sdbc_pkg;

  // Default geometry
  localparam int unsigned EntriesDef   = 128;
  localparam int unsigned AddrBitsDef  = 32;
  localparam int unsigned RingSlots    = 256;

  // Command codes carried by func
  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_REBUILD = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_HIT        = 3'd0,
    STAT_MISS       = 3'd1,
    STAT_MISS_EMPTY = 3'd2,
    STAT_TICK_DONE  = 3'd3,
    STAT_INIT_DONE  = 3'd4
  } status_e;

  // Configuration register indexes
  localparam logic [2:0] CfgShortCount = 3'd0;
  localparam logic [2:0] CfgLongCount  = 3'd1;
  localparam logic [2:0] CfgShortBytes = 3'd2;
  localparam logic [2:0] CfgLongBytes  = 3'd3;
  localparam logic [2:0] CfgShortLife  = 3'd4;
  localparam logic [2:0] CfgLongLife   = 3'd5;

  // Configuration reset values
  localparam logic [7:0]  RstShortCount = 8'd96;
  localparam logic [7:0]  RstLongCount  = 8'd16;
  localparam logic [12:0] RstShortBytes = 13'h5A0;
  localparam logic [12:0] RstLongBytes  = 13'h180;
  localparam logic [7:0]  RstShortLife  = 8'd2;
  localparam logic [7:0]  RstLongLife   = 8'd60;

endpackage

@@ rtl/sdbc_if.sv @@
// ----------------------------------------------------------------------------
// sdbc request and response channels
// Valid/ready channels of the sample DMA buffer cache.
// ----------------------------------------------------------------------------
interface sdbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] device_address;
  logic [12:0] request_bytes;
  logic        persistent;
  logic [7:0]  hint_index;

  modport source (output valid, func, device_address, request_bytes, persistent,
                  hint_index, input ready);
  modport sink (input valid, func, device_address, request_bytes, persistent,
                hint_index, output ready);
endinterface

interface sdbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  entry_index;
  logic [11:0] buffer_offset;
  logic [6:0]  buffer_entry;
  logic        dma_start;
  logic [31:0] dma_source;
  logic [12:0] dma_length;

  modport source (output valid, status, entry_index, buffer_offset, buffer_entry,
                  dma_start, dma_source, dma_length, input ready);
  modport sink (input valid, status, entry_index, buffer_offset, buffer_entry,
                dma_start, dma_source, dma_length, output ready);
endinterface

@@ rtl/sample_dma_buffer_cache_unit.sv @@
// ----------------------------------------------------------------------------
// sample_dma_buffer_cache_unit
// DMA staging-buffer cache with a short-lived and a persistent pool.
// ----------------------------------------------------------------------------
// One command is worked on at a time; the entry tables sit in synchronous
// memories with separate read and write ports, read one entry per cycle. A
// request scans the entries of its pool (short pool, or persistent pool)
// one per cycle, with a swap step added when a hit has to pull the entry
// out of its ring. A frame tick walks every pool entry once. A rebuild and
// the clearing pass after reset write one ring slot per cycle; no command
// is taken during either.
// Results wait in an output register, so the next command can be taken while
// a result is still pending.
module sample_dma_buffer_cache_unit #(
  parameter int unsigned ENTRIES      = sdbc_pkg::EntriesDef,
  parameter int unsigned ADDRESS_BITS = sdbc_pkg::AddrBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sdbc_req_if.sink    req_i,
  sdbc_rsp_if.source  rsp_o
);

  localparam int EW = $clog2(ENTRIES);
  localparam int AW = ADDRESS_BITS;
  localparam int RS = sdbc_pkg::RingSlots;
  localparam logic [8:0] Ent9 = 9'(ENTRIES);
  localparam logic [8:0] LastSlot = 9'(RS - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_HIT, S_UQ, S_MISS, S_ALLOC, S_TICK, S_RESP
  } state_e;

  // Configuration registers
  logic [7:0]  s_count_q, l_count_q, s_life_q, l_life_q;
  logic [12:0] s_bytes_q, l_bytes_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_count_q <= sdbc_pkg::RstShortCount;
      l_count_q <= sdbc_pkg::RstLongCount;
      s_bytes_q <= sdbc_pkg::RstShortBytes;
      l_bytes_q <= sdbc_pkg::RstLongBytes;
      s_life_q  <= sdbc_pkg::RstShortLife;
      l_life_q  <= sdbc_pkg::RstLongLife;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        sdbc_pkg::CfgShortCount: s_count_q <= pwdata[7:0];
        sdbc_pkg::CfgLongCount:  l_count_q <= pwdata[7:0];
        sdbc_pkg::CfgShortBytes: s_bytes_q <= pwdata[12:0];
        sdbc_pkg::CfgLongBytes:  l_bytes_q <= pwdata[12:0];
        sdbc_pkg::CfgShortLife:  s_life_q  <= pwdata[7:0];
        sdbc_pkg::CfgLongLife:   l_life_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (paddr[4:2])
      sdbc_pkg::CfgShortCount: prdata = {24'd0, s_count_q};
      sdbc_pkg::CfgLongCount:  prdata = {24'd0, l_count_q};
      sdbc_pkg::CfgShortBytes: prdata = {19'd0, s_bytes_q};
      sdbc_pkg::CfgLongBytes:  prdata = {19'd0, l_bytes_q};
      sdbc_pkg::CfgShortLife:  prdata = {24'd0, s_life_q};
      sdbc_pkg::CfgLongLife:   prdata = {24'd0, l_life_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // Clamp pool sizes to the table
  logic [8:0] s_raw9, l_raw9, s9, room9, l9, end9;
  assign s_raw9 = {1'b0, s_count_q};
  assign l_raw9 = {1'b0, l_count_q};
  assign s9     = (s_raw9 > Ent9) ? Ent9 : s_raw9;
  assign room9  = Ent9 - s9;
  assign l9     = (l_raw9 > room9) ? room9 : l_raw9;
  assign end9   = s9 + l9;

  // Ring contents reduced to an entry number
  logic [EW-1:0] fix_tbl [RS];
  for (genvar g = 0; g < RS; g++) begin : g_fix
    assign fix_tbl[g] = EW'(g % ENTRIES);
  end

  // Memory ports
  logic          src_we, ttl_we, slot_we, sr_we, lr_we;
  logic [EW-1:0] src_wa, ttl_wa, slot_wa, ent_ra;
  logic [AW-1:0] src_wd, src_rd_q;
  logic [7:0]    ttl_wd, slot_wd, ttl_rd_q, slot_rd_q;
  logic [7:0]    sr_wa, sr_wd, sr_ra, sr_rd_q, lr_wa, lr_wd, lr_ra, lr_rd_q;

  logic [AW-1:0] src_mem  [ENTRIES];
  logic [7:0]    ttl_mem  [ENTRIES];
  logic [7:0]    slot_mem [ENTRIES];
  logic [7:0]    sr_mem   [RS];
  logic [7:0]    lr_mem   [RS];

  // Entry tables
  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    if (ttl_we) ttl_mem[ttl_wa] <= ttl_wd;
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    src_rd_q  <= src_mem[ent_ra];
    ttl_rd_q  <= ttl_mem[ent_ra];
    slot_rd_q <= slot_mem[ent_ra];
  end

  // Reuse rings
  always_ff @(posedge clk_i) begin
    if (sr_we) sr_mem[sr_wa] <= sr_wd;
    if (lr_we) lr_mem[lr_wa] <= lr_wd;
    sr_rd_q <= sr_mem[sr_ra];
    lr_rd_q <= lr_mem[lr_ra];
  end

  // Control state
  state_e            state_q, state_d;
  logic [8:0]        k_q, k_d, cnt_q, cnt_d;
  logic              rd_v_q, rd_v_d, rd_last_q, rd_last_d;
  logic [EW-1:0]     rd_idx_q, rd_idx_d;
  logic              init_rsp_q, init_rsp_d;
  logic              long_q, long_d, pers_q, pers_d, use_long_q, use_long_d;
  logic              empty_q, empty_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [12:0]       len_q, len_d;
  logic [7:0]        hint_q, hint_d;
  logic [EW-1:0]     hit_idx_q, hit_idx_d;
  logic [7:0]        hit_ttl_q, hit_ttl_d, hit_slot_q, hit_slot_d;
  logic [11:0]       off_q, off_d;
  logic [7:0]        shead_q, shead_d, stail_q, stail_d, lhead_q, lhead_d;
  logic [7:0]        ltail_q, ltail_d;
  // Pending result
  sdbc_pkg::status_e res_stat_q, res_stat_d;
  logic [7:0]        res_idx_q, res_idx_d;
  logic [11:0]       res_off_q, res_off_d;
  logic [6:0]        res_ent_q, res_ent_d;
  logic              res_dma_q, res_dma_d;
  logic [31:0]       res_src_q, res_src_d;
  logic [12:0]       res_len_q, res_len_d;
  // Output register
  logic              out_v_q, out_v_d;
  logic [2:0]        out_stat_q, out_stat_d;
  logic [7:0]        out_idx_q, out_idx_d;
  logic [11:0]       out_off_q, out_off_d;
  logic [6:0]        out_ent_q, out_ent_d;
  logic              out_dma_q, out_dma_d;
  logic [31:0]       out_src_q, out_src_d;
  logic [12:0]       out_len_q, out_len_d;

  // Helpers
  logic          in_fire, ent_hit, uq_need, short_hit, tick_short;
  logic [EW-1:0] cand, new_e, moved_e;
  logic [12:0]   bs, bs_m_len;
  logic [AW-1:0] diff, aligned;
  logic [7:0]    uq_tail, moved, sweep_i, ttl_dec;
  logic [8:0]    sweep9;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid & req_i.ready;

  // Range test of the entry just read
  assign bs       = long_q ? l_bytes_q : s_bytes_q;
  assign bs_m_len = bs - len_q;
  assign diff     = addr_q - src_rd_q;
  assign ent_hit  = (addr_q >= src_rd_q) && (len_q <= bs) && (diff <= AW'(bs_m_len));
  assign aligned  = {addr_q[AW-1:4], 4'b0000};

  always_comb begin
    // Hold by default
    state_d    = state_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    rd_v_d     = 1'b0;
    rd_last_d  = rd_last_q;
    rd_idx_d   = rd_idx_q;
    init_rsp_d = init_rsp_q;
    long_d     = long_q;
    pers_d     = pers_q;
    use_long_d = use_long_q;
    empty_d    = empty_q;
    addr_d     = addr_q;
    len_d      = len_q;
    hint_d     = hint_q;
    hit_idx_d  = hit_idx_q;
    hit_ttl_d  = hit_ttl_q;
    hit_slot_d = hit_slot_q;
    off_d      = off_q;
    shead_d    = shead_q;
    stail_d    = stail_q;
    lhead_d    = lhead_q;
    ltail_d    = ltail_q;
    res_stat_d = res_stat_q;
    res_idx_d  = res_idx_q;
    res_off_d  = res_off_q;
    res_ent_d  = res_ent_q;
    res_dma_d  = res_dma_q;
    res_src_d  = res_src_q;
    res_len_d  = res_len_q;

    src_we  = 1'b0; src_wa  = '0; src_wd  = '0;
    ttl_we  = 1'b0; ttl_wa  = '0; ttl_wd  = '0;
    slot_we = 1'b0; slot_wa = '0; slot_wd = '0;
    ent_ra  = '0;
    sr_we = 1'b0; sr_wa = '0; sr_wd = '0; sr_ra = '0;
    lr_we = 1'b0; lr_wa = '0; lr_wd = '0; lr_ra = '0;

    cand       = '0;
    short_hit  = ~long_q;
    uq_tail    = short_hit ? stail_q : ltail_q;
    uq_need    = short_hit ? (hit_ttl_q == 8'd0)
                           : ((hit_ttl_q == 8'd0) && (ltail_q != lhead_q));
    moved      = short_hit ? sr_rd_q : lr_rd_q;
    moved_e    = fix_tbl[moved];
    new_e      = fix_tbl[use_long_q ? lr_rd_q : sr_rd_q];
    tick_short = ({1'b0, 8'(rd_idx_q)} < s9);
    ttl_dec    = ttl_rd_q - 8'd1;
    sweep_i    = k_q[7:0];
    sweep9     = {1'b0, sweep_i};

    case (state_q)
      // Refill both rings and clear the entry tables, one slot per cycle
      S_INIT: begin
        sr_we = 1'b1;
        sr_wa = sweep_i;
        sr_wd = (sweep9 < s9) ? sweep_i : 8'd0;
        lr_we = 1'b1;
        lr_wa = sweep_i;
        lr_wd = (sweep9 < l9) ? 8'(s9 + sweep9) : 8'(s9);
        if (k_q < Ent9) begin
          src_we  = 1'b1; src_wa  = EW'(k_q); src_wd = '0;
          ttl_we  = 1'b1; ttl_wa  = EW'(k_q); ttl_wd = 8'd0;
          slot_we = 1'b1; slot_wa = EW'(k_q);
          if (sweep9 < s9) begin
            slot_wd = sweep_i;
          end else if (sweep9 < end9) begin
            slot_wd = 8'(sweep9 - s9);
          end else begin
            slot_wd = 8'd0;
          end
        end
        k_d = k_q + 9'd1;
        if (k_q == LastSlot) begin
          shead_d = 8'(s9);
          lhead_d = 8'(l9);
          stail_d = 8'd0;
          ltail_d = 8'd0;
          if (init_rsp_q) begin
            res_stat_d = sdbc_pkg::STAT_INIT_DONE;
            res_idx_d = '0; res_off_d = '0; res_ent_d = '0;
            res_dma_d = 1'b0; res_src_d = '0; res_len_d = '0;
            state_d = S_RESP;
          end else begin
            state_d = S_IDLE;
          end
          init_rsp_d = 1'b0;
        end
      end

      // Take a command
      S_IDLE: begin
        if (in_fire) begin
          addr_d = req_i.device_address[AW-1:0];
          len_d  = req_i.request_bytes;
          pers_d = req_i.persistent;
          hint_d = req_i.hint_index;
          k_d    = 9'd0;
          case (req_i.func)
            sdbc_pkg::FUNC_REQUEST: begin
              long_d  = req_i.persistent | ({1'b0, req_i.hint_index} >= s9);
              cnt_d   = long_d ? l9 : s9;
              state_d = (cnt_d == 9'd0) ? S_MISS : S_SCAN;
            end
            sdbc_pkg::FUNC_TICK: begin
              cnt_d = end9;
              if (end9 == 9'd0) begin
                res_stat_d = sdbc_pkg::STAT_TICK_DONE;
                res_idx_d = '0; res_off_d = '0; res_ent_d = '0;
                res_dma_d = 1'b0; res_src_d = '0; res_len_d = '0;
                state_d = S_RESP;
              end else begin
                state_d = S_TICK;
              end
            end
            sdbc_pkg::FUNC_REBUILD: begin
              init_rsp_d = 1'b1;
              state_d    = S_INIT;
            end
            default: ;
          endcase
        end
      end

      // Read one candidate per cycle, test the one read last cycle
      S_SCAN: begin
        if (long_q) begin
          cand = EW'(s9 + k_q);
        end else if (k_q == 9'd0) begin
          cand = hint_q[EW-1:0];
        end else begin
          cand = EW'(k_q - 9'd1);
        end
        if (k_q < cnt_q) begin
          ent_ra    = cand;
          rd_v_d    = 1'b1;
          rd_last_d = (k_q == cnt_q - 9'd1);
          rd_idx_d  = cand;
          k_d       = k_q + 9'd1;
        end
        if (rd_v_q) begin
          if (ent_hit) begin
            hit_idx_d  = rd_idx_q;
            hit_ttl_d  = ttl_rd_q;
            hit_slot_d = slot_rd_q;
            off_d      = diff[11:0];
            rd_v_d     = 1'b0;
            state_d    = S_HIT;
          end else if (rd_last_q) begin
            rd_v_d  = 1'b0;
            state_d = S_MISS;
          end
        end
      end

      // Refresh the TTL, start pulling the entry out of its ring
      S_HIT: begin
        ttl_we = 1'b1;
        ttl_wa = hit_idx_q;
        ttl_wd = short_hit ? s_life_q : l_life_q;
        res_stat_d = sdbc_pkg::STAT_HIT;
        res_idx_d  = short_hit ? hint_q : 8'(hit_idx_q);
        res_off_d  = off_q;
        res_ent_d  = 7'(hit_idx_q);
        res_dma_d  = 1'b0;
        res_src_d  = '0;
        res_len_d  = '0;
        state_d    = S_RESP;
        if (uq_need) begin
          if (hit_slot_q != uq_tail) begin
            sr_ra   = stail_q;
            lr_ra   = ltail_q;
            state_d = S_UQ;
          end else if (short_hit) begin
            stail_d = stail_q + 8'd1;
          end else begin
            ltail_d = ltail_q + 8'd1;
          end
        end
      end

      // Swap with the tail entry and advance the tail
      S_UQ: begin
        slot_we = 1'b1;
        slot_wa = moved_e;
        slot_wd = hit_slot_q;
        if (short_hit) begin
          sr_we   = 1'b1; sr_wa = hit_slot_q; sr_wd = moved;
          stail_d = stail_q + 8'd1;
        end else begin
          lr_we   = 1'b1; lr_wa = hit_slot_q; lr_wd = moved;
          ltail_d = ltail_q + 8'd1;
        end
        state_d = S_RESP;
      end

      // Pop an entry off a ring
      S_MISS: begin
        use_long_d = long_q & pers_q & (ltail_q != lhead_q);
        empty_d    = 1'b0;
        if (use_long_d) begin
          lr_ra   = ltail_q;
          ltail_d = ltail_q + 8'd1;
        end else begin
          sr_ra   = stail_q;
          empty_d = (stail_q == shead_q);
          stail_d = stail_q + 8'd1;
        end
        state_d = S_ALLOC;
      end

      // Point the entry at the aligned address and order the fill
      S_ALLOC: begin
        ttl_we = 1'b1; ttl_wa = new_e; ttl_wd = s_life_q;
        src_we = 1'b1; src_wa = new_e; src_wd = aligned;
        res_stat_d = empty_q ? sdbc_pkg::STAT_MISS_EMPTY : sdbc_pkg::STAT_MISS;
        res_idx_d  = 8'(new_e);
        res_off_d  = {8'd0, addr_q[3:0]};
        res_ent_d  = 7'(new_e);
        res_dma_d  = 1'b1;
        res_src_d  = 32'(aligned);
        res_len_d  = ({1'b0, 8'(new_e)} < s9) ? s_bytes_q : l_bytes_q;
        state_d    = S_RESP;
      end

      // Age one entry per cycle, queue those that expire
      S_TICK: begin
        if (k_q < cnt_q) begin
          ent_ra    = EW'(k_q);
          rd_v_d    = 1'b1;
          rd_last_d = (k_q == cnt_q - 9'd1);
          rd_idx_d  = EW'(k_q);
          k_d       = k_q + 9'd1;
        end
        if (rd_v_q) begin
          if (ttl_rd_q != 8'd0) begin
            ttl_we = 1'b1; ttl_wa = rd_idx_q; ttl_wd = ttl_dec;
            if (ttl_dec == 8'd0) begin
              slot_we = 1'b1;
              slot_wa = rd_idx_q;
              if (tick_short) begin
                slot_wd = shead_q;
                sr_we   = 1'b1; sr_wa = shead_q; sr_wd = 8'(rd_idx_q);
                shead_d = shead_q + 8'd1;
              end else begin
                slot_wd = lhead_q;
                lr_we   = 1'b1; lr_wa = lhead_q; lr_wd = 8'(rd_idx_q);
                lhead_d = lhead_q + 8'd1;
              end
            end
          end
          if (rd_last_q) begin
            res_stat_d = sdbc_pkg::STAT_TICK_DONE;
            res_idx_d = '0; res_off_d = '0; res_ent_d = '0;
            res_dma_d = 1'b0; res_src_d = '0; res_len_d = '0;
            rd_v_d  = 1'b0;
            state_d = S_RESP;
          end
        end
      end

      // Hand the result to the output register
      S_RESP: begin
        if (!out_v_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_v_d    = out_v_q & ~rsp_o.ready;
    out_stat_d = out_stat_q;
    out_idx_d  = out_idx_q;
    out_off_d  = out_off_q;
    out_ent_d  = out_ent_q;
    out_dma_d  = out_dma_q;
    out_src_d  = out_src_q;
    out_len_d  = out_len_q;
    if ((state_q == S_RESP) && (!out_v_q || rsp_o.ready)) begin
      out_v_d    = 1'b1;
      out_stat_d = res_stat_q;
      out_idx_d  = res_idx_q;
      out_off_d  = res_off_q;
      out_ent_d  = res_ent_q;
      out_dma_d  = res_dma_q;
      out_src_d  = res_src_q;
      out_len_d  = res_len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      k_q        <= 9'd0;
      rd_v_q     <= 1'b0;
      init_rsp_q <= 1'b0;
      shead_q    <= 8'd0;
      stail_q    <= 8'd0;
      lhead_q    <= 8'd0;
      ltail_q    <= 8'd0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      rd_v_q     <= rd_v_d;
      init_rsp_q <= init_rsp_d;
      shead_q    <= shead_d;
      stail_q    <= stail_d;
      lhead_q    <= lhead_d;
      ltail_q    <= ltail_d;
      out_v_q    <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    rd_last_q  <= rd_last_d;
    rd_idx_q   <= rd_idx_d;
    long_q     <= long_d;
    pers_q     <= pers_d;
    use_long_q <= use_long_d;
    empty_q    <= empty_d;
    addr_q     <= addr_d;
    len_q      <= len_d;
    hint_q     <= hint_d;
    hit_idx_q  <= hit_idx_d;
    hit_ttl_q  <= hit_ttl_d;
    hit_slot_q <= hit_slot_d;
    off_q      <= off_d;
    res_stat_q <= res_stat_d;
    res_idx_q  <= res_idx_d;
    res_off_q  <= res_off_d;
    res_ent_q  <= res_ent_d;
    res_dma_q  <= res_dma_d;
    res_src_q  <= res_src_d;
    res_len_q  <= res_len_d;
    out_stat_q <= out_stat_d;
    out_idx_q  <= out_idx_d;
    out_off_q  <= out_off_d;
    out_ent_q  <= out_ent_d;
    out_dma_q  <= out_dma_d;
    out_src_q  <= out_src_d;
    out_len_q  <= out_len_d;
  end

  assign rsp_o.valid         = out_v_q;
  assign rsp_o.status        = out_stat_q;
  assign rsp_o.entry_index   = out_idx_q;
  assign rsp_o.buffer_offset = out_off_q;
  assign rsp_o.buffer_entry  = out_ent_q;
  assign rsp_o.dma_start     = out_dma_q;
  assign rsp_o.dma_source    = out_src_q;
  assign rsp_o.dma_length    = out_len_q;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sample DMA buffer cache. A queue of commands
// feeds a valid/ready driver; a cycle-free model of the two pools, their TTLs
// and reuse rings predicts each result, and a monitor with random stalls
// checks every response transfer in order. Directed traffic runs at the reset
// setting; several more are visited through the APB port, each with random traffic.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = sdbc_pkg::EntriesDef;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned SettleCycles = 320;

  typedef struct {
    sdbc_pkg::func_e func;
    bit [31:0]   addr;
    bit [12:0]   len;
    bit          pers;
    bit [7:0]    hint;
    bit          drain;
  } cmd_t;

  typedef struct {
    bit [2:0]    status;
    bit [7:0]    entry_index;
    bit [11:0]   buffer_offset;
    bit [6:0]    buffer_entry;
    bit          dma_start;
    bit [31:0]   dma_source;
    bit [12:0]   dma_length;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  sdbc_req_if req ();
  sdbc_rsp_if rsp ();

  sample_dma_buffer_cache_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req),
    .rsp_o   (rsp)
  );

  // Cache model: registers, entry tables and the two reuse rings
  bit [7:0]  cfg_short_count, cfg_long_count, cfg_short_life, cfg_long_life;
  bit [12:0] cfg_short_bytes, cfg_long_bytes;
  bit [31:0] ent_src [NumEntries];
  bit [7:0]  ent_ttl [NumEntries];
  bit [7:0]  ent_slot [NumEntries];
  bit [7:0]  short_ring [256];
  bit [7:0]  long_ring [256];
  bit [7:0]  short_head, short_tail, long_head, long_tail;

  cmd_t    pending_cmds[$];
  result_t expected_results[$];
  cmd_t    cur_cmd;

  int unsigned errors, n_hit, n_miss, n_empty, n_tick, n_rebuild, n_checked;
  int unsigned idle_cycles;
  int unsigned idle_mode;
  bit [31:0] recent_addr [8];

  function automatic int unsigned short_size();
    return (32'(cfg_short_count) > NumEntries) ? NumEntries : 32'(cfg_short_count);
  endfunction

  function automatic int unsigned long_size();
    int unsigned room;
    room = NumEntries - short_size();
    return (32'(cfg_long_count) > room) ? room : 32'(cfg_long_count);
  endfunction

  function automatic int unsigned buf_bytes(int unsigned e);
    return (e < short_size()) ? 32'(cfg_short_bytes) : 32'(cfg_long_bytes);
  endfunction

  // Whole request inside the entry window, checked without overflow
  function automatic bit window_hit(int unsigned e, bit [31:0] a, int unsigned len,
                                    output int unsigned off);
    int unsigned bs;
    bit [31:0] d;
    bs = buf_bytes(e);
    off = 0;
    if (a < ent_src[e] || len > bs) return 1'b0;
    d = a - ent_src[e];
    if (d > bs - len) return 1'b0;
    off = d;
    return 1'b1;
  endfunction

  // Pull an entry out of its ring by swapping with the tail
  function automatic void ring_pull(bit is_long, int unsigned e);
    bit [7:0] s, moved;
    s = ent_slot[e];
    if (is_long) begin
      if (s != long_tail) begin
        moved = long_ring[long_tail];
        long_ring[s] = moved;
        ent_slot[32'(moved) % NumEntries] = s;
      end
      long_tail = long_tail + 8'd1;
    end else begin
      if (s != short_tail) begin
        moved = short_ring[short_tail];
        short_ring[s] = moved;
        ent_slot[32'(moved) % NumEntries] = s;
      end
      short_tail = short_tail + 8'd1;
    end
  endfunction

  function automatic void rings_rebuild();
    int unsigned s, l;
    s = short_size();
    l = long_size();
    for (int i = 0; i < NumEntries; i++) begin
      ent_src[i] = '0;
      ent_ttl[i] = '0;
      ent_slot[i] = '0;
    end
    for (int unsigned i = 0; i < 256; i++) begin
      short_ring[i] = 8'((i < s) ? i : 0);
      long_ring[i] = 8'((i < l) ? s + i : s);
    end
    for (int unsigned i = 0; i < s; i++) ent_slot[i] = 8'(i);
    for (int unsigned i = 0; i < l; i++) ent_slot[s + i] = 8'(i);
    short_head = 8'(s);
    short_tail = 8'd0;
    long_head = 8'(l);
    long_tail = 8'd0;
  endfunction

  function automatic void frame_age();
    int unsigned s, last;
    s = short_size();
    last = s + long_size();
    for (int unsigned i = 0; i < last; i++) begin
      if (ent_ttl[i] != 0) begin
        ent_ttl[i] = ent_ttl[i] - 8'd1;
        if (ent_ttl[i] == 0) begin
          if (i < s) begin
            ent_slot[i] = short_head;
            short_ring[short_head] = 8'(i);
            short_head = short_head + 8'd1;
          end else begin
            ent_slot[i] = long_head;
            long_ring[long_head] = 8'(i);
            long_head = long_head + 8'd1;
          end
        end
      end
    end
  endfunction

  // Apply one accepted command to the model; returns 0 when no result follows
  function automatic bit cache_predict(input cmd_t c, output result_t r);
    int unsigned s, last, off, e, cand;
    bit got;
    r = '{default: 0};
    s = short_size();
    last = s + long_size();
    got = 1'b0;
    e = 0;
    off = 0;
    if (c.func == sdbc_pkg::FUNC_NONE) return 1'b0;
    if (c.func == sdbc_pkg::FUNC_TICK) begin
      frame_age();
      r.status = sdbc_pkg::STAT_TICK_DONE;
      return 1'b1;
    end
    if (c.func == sdbc_pkg::FUNC_REBUILD) begin
      rings_rebuild();
      r.status = sdbc_pkg::STAT_INIT_DONE;
      return 1'b1;
    end
    if (c.pers || 32'(c.hint) >= s) begin
      for (int unsigned i = s; i < last; i++) begin
        if (window_hit(i, c.addr, 32'(c.len), off)) begin
          if (ent_ttl[i] == 0 && long_tail != long_head) ring_pull(1'b1, i);
          ent_ttl[i] = cfg_long_life;
          r.status = sdbc_pkg::STAT_HIT;
          r.entry_index = 8'(i);
          r.buffer_offset = 12'(off);
          r.buffer_entry = 7'(i);
          return 1'b1;
        end
      end
      if (long_tail != long_head && c.pers) begin
        e = 32'(long_ring[long_tail]) % NumEntries;
        long_tail = long_tail + 8'd1;
        got = 1'b1;
      end
    end else begin
      // hint first, then 0..S-2
      for (int unsigned i = 0; i < s; i++) begin
        cand = (i == 0) ? 32'(c.hint) : i - 1;
        if (window_hit(cand, c.addr, 32'(c.len), off)) begin
          if (ent_ttl[cand] == 0) ring_pull(1'b0, cand);
          ent_ttl[cand] = cfg_short_life;
          r.status = sdbc_pkg::STAT_HIT;
          r.entry_index = c.hint;
          r.buffer_offset = 12'(off);
          r.buffer_entry = 7'(cand);
          return 1'b1;
        end
      end
    end
    r.status = sdbc_pkg::STAT_MISS;
    if (!got) begin
      if (short_tail == short_head) r.status = sdbc_pkg::STAT_MISS_EMPTY;
      e = 32'(short_ring[short_tail]) % NumEntries;
      short_tail = short_tail + 8'd1;
    end
    ent_ttl[e] = cfg_short_life;
    ent_src[e] = c.addr & ~32'hF;
    r.entry_index = 8'(e);
    r.buffer_offset = {8'd0, c.addr[3:0]};
    r.buffer_entry = 7'(e);
    r.dma_start = 1'b1;
    r.dma_source = ent_src[e];
    r.dma_length = 13'(buf_bytes(e));
    return 1'b1;
  endfunction

  function automatic int unsigned draw_gap();
    if (idle_mode == 0) return 0;
    if (idle_mode == 1 && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Request driver: transfer pending commands with random gaps
  int unsigned req_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.func <= sdbc_pkg::FUNC_NONE;
      req.device_address <= '0;
      req.request_bytes <= '0;
      req.persistent <= 1'b0;
      req.hint_index <= '0;
      req_gap <= 0;
    end else begin
      if (req.valid && req.ready) begin
        if (cache_predict(cur_cmd, r)) expected_results.push_back(r);
      end
      if (!req.valid || req.ready) begin
        if (req_gap != 0) begin
          req_gap <= req_gap - 1;
          req.valid <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && expected_results.size() != 0)) begin
          cur_cmd = pending_cmds.pop_front();
          req.valid <= 1'b1;
          req.func <= cur_cmd.func;
          req.device_address <= cur_cmd.addr;
          req.request_bytes <= cur_cmd.len;
          req.persistent <= cur_cmd.pers;
          req.hint_index <= cur_cmd.hint;
          req_gap <= draw_gap();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random stalls, plus the watchdog
  int unsigned rsp_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int unsigned s;
    if (!rst_ni) begin
      rsp.ready <= 1'b1;
      rsp_stall <= 0;
      idle_cycles <= 0;
    end else begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb_top: watchdog expired, %0d results outstanding",
                 expected_results.size());
        $display("tb_top: errors");
        $finish;
      end
      if (rsp_stall != 0) begin
        rsp_stall <= rsp_stall - 1;
        rsp.ready <= (rsp_stall == 1);
      end else if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("tb_top: result transfer with nothing expected");
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          case (want.status)
            sdbc_pkg::STAT_HIT:        n_hit++;
            sdbc_pkg::STAT_MISS:       n_miss++;
            sdbc_pkg::STAT_MISS_EMPTY: n_empty++;
            sdbc_pkg::STAT_TICK_DONE:  n_tick++;
            default:                   n_rebuild++;
          endcase
          if (rsp.status !== want.status || rsp.entry_index !== want.entry_index ||
              rsp.buffer_offset !== want.buffer_offset ||
              rsp.buffer_entry !== want.buffer_entry || rsp.dma_start !== want.dma_start ||
              rsp.dma_source !== want.dma_source || rsp.dma_length !== want.dma_length) begin
            errors++;
            if (errors <= 10) begin
              $display("tb_top: mismatch on result %0d", n_checked);
              $display("  exp st=%0d idx=%0d off=%0d ent=%0d dma=%0d src=%h len=%0d",
                       want.status, want.entry_index, want.buffer_offset,
                       want.buffer_entry, want.dma_start, want.dma_source,
                       want.dma_length);
              $display("  got st=%0d idx=%0d off=%0d ent=%0d dma=%0d src=%h len=%0d",
                       rsp.status, rsp.entry_index, rsp.buffer_offset,
                       rsp.buffer_entry, rsp.dma_start, rsp.dma_source, rsp.dma_length);
            end
          end
        end
        s = draw_gap();
        rsp_stall <= s;
        rsp.ready <= (s == 0);
      end
    end
  end

  task automatic push_cmd(sdbc_pkg::func_e f, bit [31:0] a, bit [12:0] len, bit pers,
                          bit [7:0] hint, bit drain = 1'b0);
    cmd_t c;
    c.func = f;
    c.addr = a;
    c.len = len;
    c.pers = pers;
    c.hint = hint;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  // Register write: setup then access cycle, model updated alongside
  task automatic reg_write(logic [2:0] idx, bit [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sdbc_pkg::CfgShortCount: cfg_short_count = val[7:0];
      sdbc_pkg::CfgLongCount:  cfg_long_count = val[7:0];
      sdbc_pkg::CfgShortBytes: cfg_short_bytes = val[12:0];
      sdbc_pkg::CfgLongBytes:  cfg_long_bytes = val[12:0];
      sdbc_pkg::CfgShortLife:  cfg_short_life = val[7:0];
      default:                 cfg_long_life = val[7:0];
    endcase
  endtask

  // Hold until every command is taken and every result is back, then settle
  task automatic drain_all();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_cmds.size() != 0 || req.valid || expected_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random traffic: addresses cluster around recent ones so hits occur
  task automatic random_traffic(int unsigned n);
    int unsigned k, pick, s;
    bit [31:0] a;
    bit [12:0] len;
    bit [7:0] hint;
    sdbc_pkg::func_e f;
    k = 0;
    s = short_size();
    while (k < n) begin
      pick = $urandom_range(0, 99);
      f = (pick < 70) ? sdbc_pkg::FUNC_REQUEST : (pick < 94) ? sdbc_pkg::FUNC_TICK :
          (pick < 97) ? sdbc_pkg::FUNC_REBUILD : sdbc_pkg::FUNC_NONE;
      pick = $urandom_range(0, 9);
      if (pick < 6) a = recent_addr[$urandom_range(0, 7)] + $urandom_range(0, 48);
      else if (pick < 9) a = recent_addr[0] + $urandom_range(0, 8192);
      else a = $urandom;
      if ($urandom_range(0, 15) == 0) recent_addr[$urandom_range(0, 7)] = a;
      pick = $urandom_range(0, 9);
      len = 13'((pick < 4) ? $urandom_range(0, 16) : (pick < 7) ? $urandom_range(0, 96) :
                (pick < 9) ? $urandom_range(0, 4096) : $urandom_range(0, 8191));
      hint = 8'(($urandom_range(0, 5) == 0 || s == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, s - 1));
      push_cmd(f, a, len, $urandom_range(0, 2) == 0, hint, k == n / 2);
      if (f != sdbc_pkg::FUNC_NONE) k++;
    end
  endtask

  task automatic set_config(bit [7:0] sc, bit [7:0] lc, bit [12:0] sb, bit [12:0] lb,
                            bit [7:0] sl, bit [7:0] ll);
    reg_write(sdbc_pkg::CfgShortCount, 32'(sc));
    reg_write(sdbc_pkg::CfgLongCount, 32'(lc));
    reg_write(sdbc_pkg::CfgShortBytes, 32'(sb));
    reg_write(sdbc_pkg::CfgLongBytes, 32'(lb));
    reg_write(sdbc_pkg::CfgShortLife, 32'(sl));
    reg_write(sdbc_pkg::CfgLongLife, 32'(ll));
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    idle_mode = 1;
    cfg_short_count = sdbc_pkg::RstShortCount;
    cfg_long_count = sdbc_pkg::RstLongCount;
    cfg_short_bytes = sdbc_pkg::RstShortBytes;
    cfg_long_bytes = sdbc_pkg::RstLongBytes;
    cfg_short_life = sdbc_pkg::RstShortLife;
    cfg_long_life = sdbc_pkg::RstLongLife;
    rings_rebuild();
    for (int i = 0; i < 8; i++) recent_addr[i] = 32'h0001_0000 + 32'(i) * 32'd1024;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes and every command
    push_cmd(sdbc_pkg::FUNC_REQUEST, 32'h0, 13'd0, 1'b0, 8'd0);
    push_cmd(sdbc_pkg::FUNC_REQUEST, 32'h0, 13'd1440, 1'b0, 8'd95);
    push_cmd(sdbc_pkg::FUNC_REQUEST, 32'hFFFF_FFFF, 13'd4096, 1'b0, 8'd3);
    push_cmd(sdbc_pkg::FUNC_REQUEST, 32'hFFFF_FFF0, 13'd16, 1'b1, 8'd255);
    push_cmd(sdbc_pkg::FUNC_REQUEST, 32'hFFFF_FFF7, 13'd8, 1'b1, 8'd200);
    push_cmd(sdbc_pkg::FUNC_REQUEST, 32'h1234_5678, 13'd8191, 1'b0, 8'd96);
    push_cmd(sdbc_pkg::FUNC_NONE, 32'hAAAA_5555, 13'h1555, 1'b1, 8'hAA);
    push_cmd(sdbc_pkg::FUNC_TICK, 32'h0, 13'd0, 1'b0, 8'd0);
    push_cmd(sdbc_pkg::FUNC_REQUEST, 32'hFFFF_FFF8, 13'd8, 1'b0, 8'd1);
    push_cmd(sdbc_pkg::FUNC_TICK, 32'h0, 13'd0, 1'b0, 8'd0, 1'b1);
    push_cmd(sdbc_pkg::FUNC_REQUEST, 32'h0000_0100, 13'd384, 1'b1, 8'd100);
    push_cmd(sdbc_pkg::FUNC_REQUEST, 32'h0000_0105, 13'd300, 1'b1, 8'd0);
    push_cmd(sdbc_pkg::FUNC_REBUILD, 32'h0, 13'd0, 1'b0, 8'd0);
    for (int i = 0; i < 6; i++) begin
      push_cmd(sdbc_pkg::FUNC_REQUEST, 32'h4000_0000 + 32'(i) * 32'd4096,
               13'd32, 1'b0, 8'd0);
    end
    drain_all();
    random_traffic(150);
    drain_all();

    // Register settings, extremes included
    for (int p = 1; p <= 6; p++) begin
      idle_mode = 32'(p % 3);
      case (p)
        1: set_config(8'd128, 8'd128, 13'd4096, 13'd16, 8'd255, 8'd1);
        2: set_config(8'd0, 8'd128, 13'd16, 13'd4096, 8'd1, 8'd255);
        3: set_config(8'd4, 8'd3, 13'd64, 13'd32, 8'd2, 8'd3);
        4: set_config(8'd8, 8'd8, 13'd8191, 13'd16, 8'd0, 8'd0);
        5: set_config(8'd255, 8'd255, 13'd1440, 13'd384, 8'd2, 8'd60);
        default: set_config(8'd2, 8'd126, 13'd48, 13'd4096, 8'd3, 8'd255);
      endcase
      // one setting runs on stale rings to cover live register changes
      if (p != 5) push_cmd(sdbc_pkg::FUNC_REBUILD, 32'h0, 13'd0, 1'b0, 8'd0);
      random_traffic(160);
      drain_all();
    end

    $display("tb_top: %0d results checked: %0d hits, %0d misses, %0d on empty ring",
             n_checked, n_hit, n_miss, n_empty);
    $display("tb_top: %0d frame ticks, %0d rebuilds over seven register settings",
             n_tick, n_rebuild);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: %0d mismatches", errors);
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sdbc_pkg.sv
rtl/sdbc_if.sv
rtl/sample_dma_buffer_cache_unit.sv
tb/sv/tb_top.sv
